>>> design/dual_stack_shared_store_core_assert.svh
// Assertion macros shared by the dual stack core modules.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef DUAL_STACK_SHARED_STORE_CORE_ASSERT_SVH
`define DUAL_STACK_SHARED_STORE_CORE_ASSERT_SVH

// same-cycle implication
`define DSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dss_pkg.sv
// Shared types and codes for the dual stack core.
// No dependencies.
package dss_pkg;

  localparam int CNT_W   = 7;   // entry counts and capacity register
  localparam int WORD_W  = 32;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
  localparam int               CAP_MAX   = (1 << CNT_W) - 1;

  typedef logic signed [WORD_W-1:0] dss_word_t;
  typedef logic [CNT_W-1:0]         dss_cnt_t;
  typedef logic [1:0]               dss_status_t;

  localparam dss_status_t ST_DONE      = 2'd0;
  localparam dss_status_t ST_OVERFLOW  = 2'd1;
  localparam dss_status_t ST_UNDERFLOW = 2'd2;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_POP   = 1'b1;
  localparam logic SEL_LOW  = 1'b0;
  localparam logic SEL_HIGH = 1'b1;

  localparam int REG_CAPACITY = 0;

  // controller -> datapath
  typedef struct packed {
    logic item_ready;
    logic exec;
    logic load_top;
    logic load_out;
  } dss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic item_valid;
    logic out_full;
  } dss_sts_t;

endpackage

>>> design/dss_item_if.sv
// Input channel of the dual stack core: one push or pop request.
// Depends on dss_pkg.
interface dss_item_if;
  import dss_pkg::*;

  logic      valid;
  logic      ready;
  logic      op;
  logic      stack_select;
  dss_word_t push_value;

  modport source (output valid, op, stack_select, push_value, input ready);
  modport sink   (input valid, op, stack_select, push_value, output ready);
endinterface

>>> design/dss_result_if.sv
// Result channel of the dual stack core: status and both tops.
// Depends on dss_pkg.
interface dss_result_if;
  import dss_pkg::*;

  logic        valid;
  logic        ready;
  dss_status_t status;
  dss_word_t   top_low_value;
  logic        top_low_valid;
  dss_word_t   top_high_value;
  logic        top_high_valid;
  logic        both_empty;

  modport source (output valid, status, top_low_value, top_low_valid,
                  top_high_value, top_high_valid, both_empty, input ready);
  modport sink   (input valid, status, top_low_value, top_low_valid,
                  top_high_value, top_high_valid, both_empty, output ready);
endinterface

>>> design/dss_ctrl.sv
// Sequencer of the dual stack core: take, execute, load top, respond.
// Depends on dss_pkg and dual_stack_shared_store_core_assert.svh.
module dss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  dss_pkg::dss_sts_t sts,
  output dss_pkg::dss_cmd_t cmd
);
  import dss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_LOAD = 4'b0100,
    S_RESP = 4'b1000
  } dss_state_t;

  dss_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.item_ready = 1'b1;
        if (sts.item_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_top = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`include "dual_stack_shared_store_core_assert.svh"

  `DSS_ASSERT_NEXT(a_take_starts_exec, state == S_IDLE && sts.item_valid, state == S_EXEC, "accepted item did not start execution")
  `DSS_ASSERT_SAME(a_out_slot_free, cmd.load_out, !sts.out_full, "result loaded over a waiting result")

endmodule

>>> design/dss_datapath.sv
// Datapath of the dual stack core: shared store, counts, tops, output register.
// Depends on dss_pkg and dual_stack_shared_store_core_assert.svh.
module dss_datapath #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dss_pkg::dss_cmd_t       cmd,
  output dss_pkg::dss_sts_t       sts,
  // configuration
  input  logic                    cfg_we,
  input  dss_pkg::dss_cnt_t       cfg_data,
  output dss_pkg::dss_cnt_t       cap,
  // item payload
  input  logic                    item_valid,
  input  logic                    item_op,
  input  logic                    item_stack_select,
  input  dss_pkg::dss_word_t      item_push_value,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output dss_pkg::dss_status_t    out_status,
  output dss_pkg::dss_word_t      out_top_low_value,
  output logic                    out_top_low_valid,
  output dss_pkg::dss_word_t      out_top_high_value,
  output logic                    out_top_high_valid,
  output logic                    out_both_empty
);
  import dss_pkg::*;

  localparam int AW        = $clog2(STORE_DEPTH);
  localparam int CAP_LIMIT = (STORE_DEPTH > CAP_MAX) ? CAP_MAX : STORE_DEPTH;

  dss_word_t   mem [STORE_DEPTH];
  dss_word_t   rd_data;

  dss_cnt_t    low_count, high_count;
  dss_cnt_t    low_next, high_next;
  dss_cnt_t    eff_cap;
  logic [CNT_W:0] total, cap_ext;

  logic        op_q, sel_q;
  dss_word_t   push_q;
  dss_status_t status_q, status_next;
  logic        pend_low, pend_high, pend_low_next, pend_high_next;
  dss_word_t   top_low, top_high;

  logic        full;
  logic        wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  dss_cnt_t    wr_idx, rd_idx;

  assign eff_cap = (cap > CNT_W'(CAP_LIMIT)) ? CNT_W'(CAP_LIMIT) : cap;
  assign total   = {1'b0, low_count} + {1'b0, high_count};
  assign cap_ext = {1'b0, eff_cap};
  assign full    = total >= cap_ext;
  assign wr_addr = AW'(wr_idx);
  assign rd_addr = AW'(rd_idx);

  assign sts.item_valid = item_valid;
  assign sts.out_full   = out_valid && !out_ready;

  // item holding register
  always_ff @(posedge clk) begin
    if (item_valid && cmd.item_ready) begin
      op_q   <= item_op;
      sel_q  <= item_stack_select;
      push_q <= item_push_value;
    end
  end

  // execute step: status, new counts, store write, top refetch address
  always_comb begin
    status_next    = ST_DONE;
    low_next       = low_count;
    high_next      = high_count;
    wr_en          = 1'b0;
    wr_idx         = low_count;
    rd_en          = 1'b0;
    rd_idx         = low_count;
    pend_low_next  = 1'b0;
    pend_high_next = 1'b0;
    if (op_q == OP_PUSH) begin
      if (full) begin
        status_next = ST_OVERFLOW;
      end else if (sel_q == SEL_LOW) begin
        wr_en    = 1'b1;
        wr_idx   = low_count;
        low_next = low_count + CNT_W'(1);
      end else begin
        wr_en     = 1'b1;
        wr_idx    = eff_cap - high_count - CNT_W'(1);
        high_next = high_count + CNT_W'(1);
      end
    end else begin
      if (sel_q == SEL_LOW) begin
        if (low_count == '0) begin
          status_next = ST_UNDERFLOW;
        end else begin
          low_next      = low_count - CNT_W'(1);
          pend_low_next = low_count >= CNT_W'(2);
          rd_en         = pend_low_next;
          rd_idx        = low_count - CNT_W'(2);
        end
      end else begin
        if (high_count == '0) begin
          status_next = ST_UNDERFLOW;
        end else begin
          high_next      = high_count - CNT_W'(1);
          pend_high_next = high_count >= CNT_W'(2);
          rd_en          = pend_high_next;
          rd_idx         = eff_cap - high_count + CNT_W'(1);
        end
      end
    end
  end

  // shared store, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= push_q;
    end
    if (cmd.exec && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // counts and capacity; a capacity write empties both stacks
  always_ff @(posedge clk) begin
    if (rst) begin
      low_count  <= '0;
      high_count <= '0;
      cap        <= CAP_RESET;
    end else if (cfg_we) begin
      low_count  <= '0;
      high_count <= '0;
      cap        <= cfg_data;
    end else if (cmd.exec) begin
      low_count  <= low_next;
      high_count <= high_next;
    end
  end

  // top copies: pushed word on push, refetched word after pop
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_q  <= status_next;
      pend_low  <= pend_low_next;
      pend_high <= pend_high_next;
      if (op_q == OP_PUSH && !full) begin
        if (sel_q == SEL_LOW) begin
          top_low <= push_q;
        end else begin
          top_high <= push_q;
        end
      end
    end
    if (cmd.load_top) begin
      if (pend_low) begin
        top_low <= rd_data;
      end
      if (pend_high) begin
        top_high <= rd_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status         <= status_q;
      out_top_low_valid  <= low_count != '0;
      out_top_low_value  <= (low_count != '0) ? top_low : '0;
      out_top_high_valid <= high_count != '0;
      out_top_high_value <= (high_count != '0) ? top_high : '0;
      out_both_empty     <= total == '0;
    end
  end

`include "dual_stack_shared_store_core_assert.svh"

  `DSS_ASSERT_SAME(a_counts_in_cap, 1'b1, total <= cap_ext, "stack entries exceed capacity")
  `DSS_ASSERT_NEXT(a_push_grows, cmd.exec && !cfg_we && op_q == OP_PUSH && !full, total == $past(total) + 1'b1, "accepted push did not add one entry")
  `DSS_ASSERT_NEXT(a_cfg_empties, cfg_we, total == '0, "capacity write left entries behind")

endmodule

>>> design/dual_stack_shared_store_core.sv
// A result is loaded once its item has passed the execute and load-top states
// and the output register is free. Items go one at a time through take, execute,
// refetch top and respond, the refetch using the single registered read port.
// A new item is taken while the previous result still waits in the output register.
// Reset: both stacks empty, capacity 64; store words are not cleared (no clearing pass).
module dual_stack_shared_store_core #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  dss_item_if.sink                      item,
  dss_result_if.source                  result,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dss_pkg::PADDR_W-1:0]   paddr,
  input  logic [dss_pkg::PDATA_W-1:0]   pwdata,
  output logic [dss_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import dss_pkg::*;

  dss_cmd_t cmd;
  dss_sts_t sts;
  dss_cnt_t cap;
  logic     cfg_we;

  // Single register: capacity_in_use sits at byte address 0. Any completed
  // write lands there; only the low CNT_W bits are kept.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[PADDR_W-1:0] == PADDR_W'(REG_CAPACITY * 4))
                  ? PDATA_W'(cap) : PDATA_W'(cap);

  assign item.ready = cmd.item_ready;

  dss_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Low stack fills upward from word 0, high stack downward from the word
  // just under the effective capacity (capacity clamped to the store depth).
  dss_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_data           (pwdata[CNT_W-1:0]),
    .cap                (cap),
    .item_valid         (item.valid),
    .item_op            (item.op),
    .item_stack_select  (item.stack_select),
    .item_push_value    (item.push_value),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .out_status         (result.status),
    .out_top_low_value  (result.top_low_value),
    .out_top_low_valid  (result.top_low_valid),
    .out_top_high_value (result.top_high_value),
    .out_top_high_valid (result.top_high_valid),
    .out_both_empty     (result.both_empty)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for dual_stack_shared_store_core: directed table, then random phases.
// Depends on dss_pkg and the dss_item_if / dss_result_if interfaces from the design folder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  localparam int DEPTH      = 64;
  localparam int HALF_CLK   = 5;
  localparam int RST_CYCLES = 10;
  localparam int LAT_CYCLES = 6;       // settle time after the last result
  localparam int LIMIT      = 400000;  // cycle budget for the whole run
  localparam int N_PHASES   = 13;

  // One result as seen on the output channel.
  typedef struct packed {
    dss_status_t status;
    dss_word_t   low_val;
    logic        low_vld;
    dss_word_t   high_val;
    logic        high_vld;
    logic        both_empty;
  } stack_view_t;

  // Directed table rows: item checked by the predictor, item with a typed
  // expectation, or a capacity register write.
  typedef enum logic [1:0] {ROW_ITEM, ROW_CHECK, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic        sel;
    dss_word_t   value;
    dss_cnt_t    cap;
    stack_view_t want;
  } dir_row_t;

  localparam stack_view_t NO_VIEW    = '{ST_DONE, 32'h0, 1'b0, 32'h0, 1'b0, 1'b0};
  localparam stack_view_t EMPTY_UF   = '{ST_UNDERFLOW, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1};
  localparam stack_view_t EMPTY_OF   = '{ST_OVERFLOW, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1};

  localparam int N_DIR = 27;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // after reset: both pops underflow, nothing on top
    '{ROW_CHECK, OP_POP,  SEL_LOW,  32'h0,        7'd0, EMPTY_UF},
    '{ROW_CHECK, OP_POP,  SEL_HIGH, 32'h0,        7'd0, EMPTY_UF},
    // word extremes on both stacks
    '{ROW_CHECK, OP_PUSH, SEL_LOW,  32'h7fffffff, 7'd0,
      '{ST_DONE, 32'h7fffffff, 1'b1, 32'h0, 1'b0, 1'b0}},
    '{ROW_CHECK, OP_PUSH, SEL_HIGH, 32'h80000000, 7'd0,
      '{ST_DONE, 32'h7fffffff, 1'b1, 32'h80000000, 1'b1, 1'b0}},
    '{ROW_ITEM,  OP_PUSH, SEL_LOW,  32'h00000000, 7'd0, NO_VIEW},
    '{ROW_ITEM,  OP_PUSH, SEL_HIGH, 32'hffffffff, 7'd0, NO_VIEW},
    '{ROW_ITEM,  OP_POP,  SEL_LOW,  32'h0,        7'd0, NO_VIEW},
    '{ROW_ITEM,  OP_POP,  SEL_HIGH, 32'h0,        7'd0, NO_VIEW},
    '{ROW_ITEM,  OP_POP,  SEL_LOW,  32'h0,        7'd0, NO_VIEW},
    '{ROW_ITEM,  OP_POP,  SEL_HIGH, 32'h0,        7'd0, NO_VIEW},
    // capacity of one: one entry fills the store
    '{ROW_CAP,   OP_PUSH, SEL_LOW,  32'h0,        7'd1, NO_VIEW},
    '{ROW_CHECK, OP_PUSH, SEL_HIGH, 32'h55555555, 7'd0,
      '{ST_DONE, 32'h0, 1'b0, 32'h55555555, 1'b1, 1'b0}},
    '{ROW_CHECK, OP_PUSH, SEL_LOW,  32'haaaaaaaa, 7'd0,
      '{ST_OVERFLOW, 32'h0, 1'b0, 32'h55555555, 1'b1, 1'b0}},
    '{ROW_CHECK, OP_POP,  SEL_HIGH, 32'h0,        7'd0,
      '{ST_DONE, 32'h0, 1'b0, 32'h0, 1'b0, 1'b1}},
    '{ROW_ITEM,  OP_PUSH, SEL_LOW,  32'h12345678, 7'd0, NO_VIEW},
    '{ROW_ITEM,  OP_PUSH, SEL_HIGH, 32'h0f0f0f0f, 7'd0, NO_VIEW},
    // zero capacity, written while the low stack holds an entry
    '{ROW_CAP,   OP_PUSH, SEL_LOW,  32'h0,        7'd0, NO_VIEW},
    '{ROW_CHECK, OP_POP,  SEL_LOW,  32'h0,        7'd0, EMPTY_UF},
    '{ROW_CHECK, OP_PUSH, SEL_LOW,  32'hffffffff, 7'd0, EMPTY_OF},
    '{ROW_CHECK, OP_PUSH, SEL_HIGH, 32'h00000001, 7'd0, EMPTY_OF},
    // capacity above the store depth is clamped
    '{ROW_CAP,   OP_PUSH, SEL_LOW,  32'h0,        7'd127, NO_VIEW},
    '{ROW_ITEM,  OP_PUSH, SEL_HIGH, 32'hdeadbeef, 7'd0, NO_VIEW},
    '{ROW_ITEM,  OP_PUSH, SEL_LOW,  32'h80000001, 7'd0, NO_VIEW},
    '{ROW_ITEM,  OP_POP,  SEL_HIGH, 32'h0,        7'd0, NO_VIEW},
    // rewrite with the low stack non-empty: both stacks empty again
    '{ROW_CAP,   OP_PUSH, SEL_LOW,  32'h0,        7'd64, NO_VIEW},
    '{ROW_CHECK, OP_POP,  SEL_LOW,  32'h0,        7'd0, EMPTY_UF},
    '{ROW_CHECK, OP_PUSH, SEL_HIGH, 32'h7ffffffe, 7'd0,
      '{ST_DONE, 32'h0, 1'b0, 32'h7ffffffe, 1'b1, 1'b0}}
  };

  // Capacity per random phase; the last phase draws its own.
  localparam dss_cnt_t PHASE_CAPS [N_PHASES] = '{
    7'd64, 7'd1, 7'd2, 7'd127, 7'd5, 7'd64, 7'd0, 7'd33, 7'd100, 7'd3, 7'd64, 7'd63, 7'd17
  };

  logic clk = 1'b0;
  logic rst;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  dss_item_if   item_ch ();
  dss_result_if result_ch ();

  dual_stack_shared_store_core #(.STORE_DEPTH(DEPTH)) u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #HALF_CLK clk = ~clk;

  // Predictor state: shadow of the store, both depths and the capacity setting.
  dss_word_t   store_copy [DEPTH];
  int unsigned low_depth;
  int unsigned high_depth;
  dss_cnt_t    cap_setting;

  stack_view_t tops_q [$];     // results still owed by the block
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          burst_left     = 0;

  // Receiver stall pattern state.
  int          pat_left  = 0;
  logic [7:0]  stall_pat = 8'hff;
  logic [2:0]  pat_idx   = '0;

  // Applies one push/pop to the shadow state and returns the expected view.
  // Depths never exceed the clamped capacity, so every index stays in range.
  function automatic stack_view_t apply_stack_op(logic op, logic sel, dss_word_t value);
    stack_view_t view;
    int unsigned eff_cap;
    view    = NO_VIEW;
    eff_cap = (cap_setting > DEPTH) ? DEPTH : cap_setting;
    if (op == OP_PUSH) begin
      if (low_depth + high_depth >= eff_cap) begin
        view.status = ST_OVERFLOW;
      end else if (sel == SEL_LOW) begin
        store_copy[low_depth] = value;
        low_depth++;
      end else begin
        high_depth++;
        store_copy[eff_cap - high_depth] = value;
      end
    end else if (sel == SEL_LOW) begin
      if (low_depth == 0) view.status = ST_UNDERFLOW;
      else low_depth--;
    end else begin
      if (high_depth == 0) view.status = ST_UNDERFLOW;
      else high_depth--;
    end
    if (low_depth != 0) begin
      view.low_val = store_copy[low_depth - 1];
      view.low_vld = 1'b1;
    end
    if (high_depth != 0) begin
      view.high_val = store_copy[eff_cap - high_depth];
      view.high_vld = 1'b1;
    end
    view.both_empty = (low_depth == 0) && (high_depth == 0);
    return view;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Sends one item; called and returns at a falling edge. Valid is left high
  // so that back-to-back items keep it up without a drop in between.
  task automatic send_item(input logic op, input logic sel, input dss_word_t value,
                           input logic typed, input stack_view_t typed_view);
    stack_view_t view;
    if (burst_left == 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
    item_ch.valid        = 1'b1;
    item_ch.op           = op;
    item_ch.stack_select = sel;
    item_ch.push_value   = value;
    do @(posedge clk); while (!item_ch.ready);
    view = apply_stack_op(op, sel, value);
    tops_q.push_back(typed ? typed_view : view);
    burst_left--;
    @(negedge clk);
  endtask

  // Drops valid and waits at falling edges until every result has come back.
  task automatic drain;
    item_ch.valid = 1'b0;
    while (tops_q.size() != 0) @(negedge clk);
    repeat (LAT_CYCLES) @(negedge clk);
  endtask

  // One APB transfer: setup, access, done at the edge where pready is high.
  task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PADDR_W'(4 * REG_CAPACITY);
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Capacity writes happen only with the block idle; the write also empties
  // both stacks, so the shadow depths go back to zero.
  task automatic set_capacity(input dss_cnt_t cap);
    logic [PDATA_W-1:0] rd;
    drain();
    apb_access(1'b1, PDATA_W'(cap), rd);
    apb_access(1'b0, '0, rd);
    check_field("capacity readback", 32'(cap), 32'(rd[CNT_W-1:0]));
    cap_setting = cap;
    low_depth   = 0;
    high_depth  = 0;
  endtask

  // Output check: every accepted result against the oldest expectation.
  always @(posedge clk) begin : result_check
    stack_view_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (tops_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %h", $time,
                 result_ch.status);
        mismatch_count++;
      end else begin
        want = tops_q.pop_front();
        check_field("status", 32'(want.status), 32'(result_ch.status));
        check_field("top_low_value", want.low_val, result_ch.top_low_value);
        check_field("top_low_valid", 32'(want.low_vld), 32'(result_ch.top_low_valid));
        check_field("top_high_value", want.high_val, result_ch.top_high_value);
        check_field("top_high_valid", 32'(want.high_vld), 32'(result_ch.top_high_valid));
        check_field("both_empty", 32'(want.both_empty), 32'(result_ch.both_empty));
      end
    end
  end

  // Receiver: ready follows a repeating 8-bit stall pattern that is redrawn after
  // a random stretch; one pattern in four is all-ready.
  always @(negedge clk) begin
    if (pat_left == 0) begin
      pat_left  = $urandom_range(8, 64);
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
    end
    pat_left--;
    result_ch.ready = stall_pat[pat_idx];
    pat_idx++;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          n_items;
    int          pct_fill;
    int          pct_drain;
    logic        op;
    dss_word_t   value;
    dss_cnt_t    cap;

    // every input known from time zero
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.op           = OP_PUSH;
    item_ch.stack_select = SEL_LOW;
    item_ch.push_value   = '0;
    result_ch.ready      = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    cap_setting          = CAP_RESET;
    low_depth            = 0;
    high_depth           = 0;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (DIR_ROWS[i]) begin
      case (DIR_ROWS[i].kind)
        ROW_CAP:   set_capacity(DIR_ROWS[i].cap);
        ROW_CHECK: send_item(DIR_ROWS[i].op, DIR_ROWS[i].sel, DIR_ROWS[i].value,
                             1'b1, DIR_ROWS[i].want);
        default:   send_item(DIR_ROWS[i].op, DIR_ROWS[i].sel, DIR_ROWS[i].value,
                             1'b0, NO_VIEW);
      endcase
    end

    // Random phases: push-heavy first half to reach full, pop-heavy second
    // half to walk back to empty and underflow.
    for (int p = 0; p < N_PHASES; p++) begin
      cap = (p == N_PHASES - 1) ? dss_cnt_t'($urandom_range(1, DEPTH)) : PHASE_CAPS[p];
      set_capacity(cap);
      n_items   = (cap == 0) ? 30 : $urandom_range(110, 150);
      pct_fill  = $urandom_range(55, 85);
      pct_drain = $urandom_range(20, 45);
      for (int k = 0; k < n_items; k++) begin
        op = ($urandom_range(0, 99) < ((k < n_items / 2) ? pct_fill : pct_drain))
             ? OP_PUSH : OP_POP;
        case ($urandom_range(0, 15))
          0:       value = 32'h7fffffff;
          1:       value = 32'h80000000;
          2:       value = 32'h00000000;
          3:       value = 32'hffffffff;
          default: value = $urandom;
        endcase
        // occasional hold-off until the block has returned everything
        if ($urandom_range(0, 63) == 0) drain();
        send_item(op, 1'($urandom_range(0, 1)), value, 1'b0, NO_VIEW);
      end
    end

    drain();
    repeat (LAT_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/dss_pkg.sv
design/dss_item_if.sv
design/dss_result_if.sv
design/dss_ctrl.sv
design/dss_datapath.sv
design/dual_stack_shared_store_core.sv
tb/tb.sv
